[rtl/core/owbm_pkg.sv]
// Shared types, codes and functions for the 1-Wire bus master.
package owbm_pkg;

	// Field and counter widths.
	localparam int unsigned LIMIT_W = 10;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned IDX_W   = 3;

	// Reflected Dallas CRC-8 polynomial.
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

	// Register reset values.
	localparam logic [LIMIT_W-1:0] RST_RESET_LOW     = 10'd480;
	localparam logic [LIMIT_W-1:0] RST_PRES_SAMPLE   = 10'd70;
	localparam logic [LIMIT_W-1:0] RST_RESET_TAIL    = 10'd410;
	localparam logic [LIMIT_W-1:0] RST_WR_ONE_LOW    = 10'd6;
	localparam logic [LIMIT_W-1:0] RST_WR_ZERO_LOW   = 10'd60;
	localparam logic [LIMIT_W-1:0] RST_RD_SAMPLE     = 10'd15;
	localparam logic [LIMIT_W-1:0] RST_SLOT          = 10'd70;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_TAIL = 3'd3,
		PH_WR_SLOT  = 3'd4,
		PH_RD_SLOT  = 3'd5
	} phase_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE    = 3'd0,
		CMD_RESET   = 3'd1,
		CMD_WR_BYTE = 3'd2,
		CMD_RD_BYTE = 3'd3,
		CMD_WR_BIT  = 3'd4,
		CMD_RD_BIT  = 3'd5,
		CMD_CLR_CRC = 3'd6
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_RESET_LOW   = 3'd0,
		REG_PRES_SAMPLE = 3'd1,
		REG_RESET_TAIL  = 3'd2,
		REG_WR_ONE_LOW  = 3'd3,
		REG_WR_ZERO_LOW = 3'd4,
		REG_RD_SAMPLE   = 3'd5,
		REG_SLOT        = 3'd6
	} reg_idx_t;

	// One step of the reflected CRC-8 for a single received bit.
	function automatic logic [BYTE_W-1:0] crc_bit(input logic [BYTE_W-1:0] crc,
			input logic bit_in);
		logic [BYTE_W-1:0] shifted;
		shifted = crc >> 1;
		if (crc[0] ^ bit_in) begin
			shifted = shifted ^ CRC_POLY;
		end
		return shifted;
	endfunction

endpackage

[rtl/core/one_wire_bus_master.sv]
// Top level of the 1-Wire bus master with running CRC-8.
//
// The block takes one input transaction per clock while s_tready is high,
// and returns exactly one result transaction for each. Every input carries
// a command, a data byte, the microsecond tick strobe and the sampled line
// level; the reset, write and read sequences advance one tick count per
// input that carries a tick. All work for an input is done by the logic
// between the state registers and the result register, so a result appears
// in the cycle after its input is taken. The single result register sets the
// rate: s_tready stays high while the register is empty or being emptied,
// giving one transaction per clock whenever m_tready is high. Configuration
// writes are always taken and should only be issued while the block is idle.
module one_wire_bus_master
	import owbm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Input stream. tdata, lowest bit up: command[2:0], data_byte[7:0],
	// tick, line_level, zero fill to 16 bits.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,
	// Result stream. tdata, lowest bit up: drive_low, busy_res, done_res,
	// presence, received_byte[7:0], crc_now[7:0], zero fill to 24 bits.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,
	// Configuration write channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [LIMIT_W-1:0]  cfg_data
);

	// Configuration registers.
	logic [LIMIT_W-1:0] reset_low_q, pres_sample_q, reset_tail_q;
	logic [LIMIT_W-1:0] wr_one_low_q, wr_zero_low_q, rd_sample_q, slot_q;

	// Sequencer state.
	phase_t              phase_q, phase_d;
	logic [COUNT_W-1:0]  count_q, count_d, count_inc;
	logic [2:0]          bit_q, bit_d;
	logic [BYTE_W-1:0]   shift_q, shift_d;
	logic                pres_q, pres_d;
	logic [BYTE_W-1:0]   crc_q, crc_d;
	logic                mode_q, mode_d;
	logic [BYTE_W-1:0]   rx_q, rx_d;
	logic                done_d, drive_d;

	// Result register.
	logic                m_valid_q;
	logic [23:0]         m_data_q;

	// Input fields.
	logic [CMD_W-1:0]    in_cmd;
	logic [BYTE_W-1:0]   in_data;
	logic                in_tick, in_line;
	logic                in_acc;

	// Effective slot end and read sample point.
	logic [LIMIT_W-1:0]  slot_eff, samp_raw, samp_eff;

	assign in_cmd   = s_tdata[2:0];
	assign in_data  = s_tdata[10:3];
	assign in_tick  = s_tdata[11];
	assign in_line  = s_tdata[12];

	assign s_tready  = !m_valid_q || m_tready;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	assign count_inc = count_q + COUNT_W'(1);
	assign slot_eff  = (slot_q == '0) ? LIMIT_W'(1) : slot_q;
	assign samp_raw  = (rd_sample_q == '0) ? LIMIT_W'(1) : rd_sample_q;
	assign samp_eff  = (samp_raw > slot_eff) ? slot_eff : samp_raw;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q   <= RST_RESET_LOW;
			pres_sample_q <= RST_PRES_SAMPLE;
			reset_tail_q  <= RST_RESET_TAIL;
			wr_one_low_q  <= RST_WR_ONE_LOW;
			wr_zero_low_q <= RST_WR_ZERO_LOW;
			rd_sample_q   <= RST_RD_SAMPLE;
			slot_q        <= RST_SLOT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RESET_LOW:   reset_low_q   <= cfg_data;
				REG_PRES_SAMPLE: pres_sample_q <= cfg_data;
				REG_RESET_TAIL:  reset_tail_q  <= cfg_data;
				REG_WR_ONE_LOW:  wr_one_low_q  <= cfg_data;
				REG_WR_ZERO_LOW: wr_zero_low_q <= cfg_data;
				REG_RD_SAMPLE:   rd_sample_q   <= cfg_data;
				REG_SLOT:        slot_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state and result for the current input.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		pres_d  = pres_q;
		crc_d   = crc_q;
		mode_d  = mode_q;
		rx_d    = rx_q;
		done_d  = 1'b0;
		drive_d = 1'b0;

		unique case (phase_q) inside
			PH_RST_LOW: begin
				if (in_tick) begin
					count_d = count_inc;
					if (count_inc >= {1'b0, reset_low_q}) begin
						phase_d = PH_RST_WAIT;
						count_d = '0;
					end
				end
			end
			PH_RST_WAIT: begin
				if (in_tick) begin
					count_d = count_inc;
					if (count_inc >= {1'b0, pres_sample_q}) begin
						pres_d  = !in_line;
						phase_d = PH_RST_TAIL;
						count_d = '0;
					end
				end
			end
			PH_RST_TAIL: begin
				if (in_tick) begin
					count_d = count_inc;
					if (count_inc >= {1'b0, reset_tail_q}) begin
						phase_d = PH_IDLE;
						count_d = '0;
						done_d  = 1'b1;
					end
				end
			end
			PH_WR_SLOT, PH_RD_SLOT: begin
				if (in_tick) begin
					count_d = count_inc;
					// Read slots take the line at the sample point, LSB first.
					if (phase_q == PH_RD_SLOT && count_inc == {1'b0, samp_eff}) begin
						shift_d = {in_line, shift_q[BYTE_W-1:1]};
						crc_d   = crc_bit(crc_q, in_line);
					end
					// End of slot: next bit, or finish the operation.
					if (count_inc >= {1'b0, slot_q}) begin
						count_d = '0;
						if (phase_q == PH_WR_SLOT) begin
							shift_d = shift_d >> 1;
						end
						if (mode_q && bit_q != 3'd7) begin
							bit_d = bit_q + 3'd1;
						end else begin
							if (phase_q == PH_RD_SLOT) begin
								rx_d = mode_q ? shift_d : {7'd0, shift_d[BYTE_W-1]};
							end
							phase_d = PH_IDLE;
							bit_d   = '0;
							done_d  = 1'b1;
						end
					end
				end
			end
			default: begin
				// Idle: a new command starts here with the count at zero.
				count_d = '0;
				bit_d   = '0;
				case (in_cmd)
					CMD_RESET: phase_d = PH_RST_LOW;
					CMD_WR_BYTE: begin
						phase_d = PH_WR_SLOT;
						mode_d  = 1'b1;
						shift_d = in_data;
					end
					CMD_RD_BYTE: begin
						phase_d = PH_RD_SLOT;
						mode_d  = 1'b1;
						shift_d = '0;
					end
					CMD_WR_BIT: begin
						phase_d = PH_WR_SLOT;
						mode_d  = 1'b0;
						shift_d = {7'd0, in_data[0]};
					end
					CMD_RD_BIT: begin
						phase_d = PH_RD_SLOT;
						mode_d  = 1'b0;
						shift_d = '0;
					end
					CMD_CLR_CRC: begin
						crc_d  = '0;
						done_d = 1'b1;
					end
					default: ;
				endcase
			end
		endcase

		// Line drive follows the updated state.
		unique case (phase_d)
			PH_RST_LOW: drive_d = 1'b1;
			PH_WR_SLOT: drive_d = count_d <
				{1'b0, (shift_d[0] ? wr_one_low_q : wr_zero_low_q)};
			PH_RD_SLOT: drive_d = count_d < {1'b0, wr_one_low_q};
			default:    drive_d = 1'b0;
		endcase
	end

	// Sequencer state registers, advanced once per accepted input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			crc_q   <= '0;
			mode_q  <= 1'b0;
			rx_q    <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			count_q <= count_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			crc_q   <= crc_d;
			mode_q  <= mode_d;
			rx_q    <= rx_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_acc) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_data_q <= {4'd0, crc_d, rx_d, pres_d, done_d,
				(phase_d != PH_IDLE), drive_d};
		end
	end

	// A finished operation never reports busy in the same result.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_data_q[2] && m_data_q[1]))
		else $error("done and busy reported together");

	// The line is only driven while an operation is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[0] |-> m_data_q[1])
		else $error("line driven while idle");

	// The tick counter restarts before it passes the largest limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(1023))
		else $error("tick counter ran past the largest limit");

	// A bit position other than the first only exists inside a byte transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		bit_q != 3'd0 |-> mode_q && (phase_q == PH_WR_SLOT || phase_q == PH_RD_SLOT))
		else $error("bit position set outside a byte transfer");

endmodule
